// ===== sv/delimiter_scan_kmp_macros.svh =====
`ifndef DELIMITER_SCAN_KMP_MACROS_SVH
`define DELIMITER_SCAN_KMP_MACROS_SVH

`ifndef SYNTH
`define DSK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("delimiter_scan_kmp: assertion failed");
`define DSK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("delimiter_scan_kmp: assertion failed");
`else
`define DSK_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DSK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/dsk_pkg.sv =====
package dsk_pkg;

    localparam int MAX_DELIM  = 8;
    localparam int COUNT_BITS = 16;
    localparam int COUNT_W    = COUNT_BITS;
    localparam int PROG_W     = 4;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_BYTES = 2'd0,
        REG_DELIM_LEN   = 2'd1,
        REG_FALLBACK    = 2'd2,
        REG_BYTE_LIMIT  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_status;

    function automatic logic [7:0] delim_byte(input logic [63:0] bytes,
                                              input logic [PROG_W-1:0] m);
        logic [7:0] b;
        b = 8'd0;
        if (m < PROG_W'(MAX_DELIM) && m < PROG_W'(8)) begin
            b = bytes[{m[2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic [PROG_W-1:0] border_of(input logic [31:0] tbl,
                                                    input logic [PROG_W-1:0] m);
        logic [PROG_W-1:0] b;
        b = '0;
        if (m < PROG_W'(8)) begin
            b = tbl[{m[2:0], 2'b00} +: 4];
            if (b >= m) begin
                b = '0;
            end
        end
        return b;
    endfunction

    function automatic logic [PROG_W-1:0] eff_len(input logic [3:0] l);
        logic [PROG_W-1:0] r;
        if (l > 4'(MAX_DELIM)) begin
            r = PROG_W'(MAX_DELIM);
        end else begin
            r = PROG_W'(l);
        end
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] eff_limit(input logic [15:0] lim);
        logic [COUNT_W-1:0] r;
        if (64'(lim) > COUNT_MAX) begin
            r = COUNT_W'(COUNT_MAX);
        end else begin
            r = COUNT_W'(lim);
        end
        return r;
    endfunction

endpackage

// ===== sv/dsk_if.sv =====
interface dsk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;
    logic       restart;

    modport source (output valid, output data_byte, output stream_end, output restart,
                    input ready);
    modport sink (input valid, input data_byte, input stream_end, input restart,
                  output ready);
endinterface

interface dsk_out_if;
    logic        valid;
    logic        ready;
    logic        byte_taken;
    logic [3:0]  progress;
    logic [15:0] taken_count;
    logic        found;
    logic        failed;

    modport source (output valid, output byte_taken, output progress, output taken_count,
                    output found, output failed, input ready);
    modport sink (input valid, input byte_taken, input progress, input taken_count,
                  input found, input failed, output ready);
endinterface

// ===== sv/dsk_ctrl.sv =====
module dsk_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dsk_pkg::t_status i_status,
    output dsk_pkg::t_cmd   o_cmd
);

    dsk_pkg::t_state r_state;
    dsk_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsk_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsk_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.need_scan ? dsk_pkg::ST_SCAN : dsk_pkg::ST_EMIT;
                end
            end
            dsk_pkg::ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = dsk_pkg::ST_EMIT;
                end
            end
            dsk_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = dsk_pkg::ST_IDLE;
                end
            end
            default: n_state = dsk_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            dsk_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dsk_pkg::ST_SCAN: begin
                o_cmd.step = 1'b1;
            end
            dsk_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/dsk_datapath.sv =====
module dsk_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dsk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dsk_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_stream_end,
    input  logic                            i_restart,
    input  dsk_pkg::t_cmd                   i_cmd,
    output dsk_pkg::t_status                o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_byte_taken,
    output logic [3:0]                      o_progress,
    output logic [15:0]                     o_taken_count,
    output logic                            o_found,
    output logic                            o_failed
);

    logic [63:0]                   r_delim_bytes;
    logic [3:0]                    r_delim_len;
    logic [31:0]                   r_fallback;
    logic [15:0]                   r_byte_limit;

    logic [7:0]                    r_byte;
    logic [dsk_pkg::PROG_W-1:0]    r_prog;
    logic [dsk_pkg::COUNT_W-1:0]   r_count;
    logic                          r_over;
    logic                          r_found;
    logic                          r_taken;

    logic [7:0]                    n_byte;
    logic [dsk_pkg::PROG_W-1:0]    n_prog;
    logic [dsk_pkg::COUNT_W-1:0]   n_count;
    logic                          n_over;
    logic                          n_found;
    logic                          n_taken;

    logic                          r_out_valid;
    logic                          r_o_taken;
    logic [3:0]                    r_o_prog;
    logic [15:0]                   r_o_count;
    logic                          r_o_found;
    logic                          r_o_failed;

    logic [dsk_pkg::PROG_W-1:0]    w_len;
    logic [dsk_pkg::COUNT_W-1:0]   w_limit;
    logic [dsk_pkg::PROG_W-1:0]    w_prog0;
    logic [dsk_pkg::COUNT_W-1:0]   w_count0;
    logic                          w_over0;
    logic                          w_found0;
    logic                          w_hit;
    logic [dsk_pkg::PROG_W-1:0]    w_m_next;
    logic                          w_out_free;
    logic                          w_need_scan;
    logic                          w_scan_done;

    assign w_len      = dsk_pkg::eff_len(r_delim_len);
    assign w_limit    = dsk_pkg::eff_limit(r_byte_limit);
    assign w_prog0    = i_restart ? '0 : r_prog;
    assign w_count0   = i_restart ? '0 : r_count;
    assign w_over0    = i_restart ? 1'b0 : r_over;
    assign w_found0   = i_restart ? 1'b0 : r_found;
    assign w_hit      = (r_byte == dsk_pkg::delim_byte(r_delim_bytes, r_prog));
    assign w_scan_done = w_hit || (r_prog == '0);
    assign w_m_next   = w_hit ? r_prog + 1'b1
                      : (r_prog == '0) ? '0
                      : dsk_pkg::border_of(r_fallback, r_prog);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_need_scan = 1'b0;
        if (!w_over0 && !(dsk_pkg::COUNT_W'(w_len) > w_limit) && !(w_prog0 >= w_len)
            && !(w_count0 >= w_limit) && !i_stream_end) begin
            w_need_scan = 1'b1;
        end
    end

    always_comb begin
        n_byte  = r_byte;
        n_prog  = r_prog;
        n_count = r_count;
        n_over  = r_over;
        n_found = r_found;
        n_taken = r_taken;
        if (i_cmd.load) begin
            n_byte  = i_data_byte;
            n_prog  = w_prog0;
            n_count = w_count0;
            n_over  = w_over0;
            n_found = w_found0;
            n_taken = 1'b0;
            if (!w_over0) begin
                if (dsk_pkg::COUNT_W'(w_len) > w_limit) begin
                    n_over  = 1'b1;
                    n_found = 1'b0;
                end else if (w_prog0 >= w_len) begin
                    n_over  = 1'b1;
                    n_found = 1'b1;
                end else if (w_count0 >= w_limit || i_stream_end) begin
                    n_over  = 1'b1;
                    n_found = 1'b0;
                end else begin
                    n_taken = 1'b1;
                    n_count = w_count0 + 1'b1;
                end
            end
        end else if (i_cmd.step) begin
            n_prog = w_m_next;
            if (w_scan_done) begin
                if (w_m_next >= w_len) begin
                    n_over  = 1'b1;
                    n_found = 1'b1;
                end else if (r_count >= w_limit) begin
                    n_over  = 1'b1;
                    n_found = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_bytes <= '0;
            r_delim_len   <= '0;
            r_fallback    <= '0;
            r_byte_limit  <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (dsk_pkg::t_cfg_reg'(i_cfg_idx))
                dsk_pkg::REG_DELIM_BYTES: r_delim_bytes <= i_cfg_wdata;
                dsk_pkg::REG_DELIM_LEN:   r_delim_len   <= i_cfg_wdata[3:0];
                dsk_pkg::REG_FALLBACK:    r_fallback    <= i_cfg_wdata[31:0];
                dsk_pkg::REG_BYTE_LIMIT:  r_byte_limit  <= i_cfg_wdata[15:0];
                default: r_byte_limit <= r_byte_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog  <= '0;
            r_count <= '0;
            r_over  <= 1'b0;
            r_found <= 1'b0;
            r_taken <= 1'b0;
        end else begin
            r_prog  <= n_prog;
            r_count <= n_count;
            r_over  <= n_over;
            r_found <= n_found;
            r_taken <= n_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_taken  <= r_taken;
            r_o_prog   <= 4'(r_prog);
            r_o_count  <= 16'(r_count);
            r_o_found  <= r_over && r_found;
            r_o_failed <= r_over && !r_found;
        end
    end

    assign o_status.need_scan = w_need_scan;
    assign o_status.scan_done = w_scan_done;
    assign o_status.out_free  = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_byte_taken  = r_o_taken;
    assign o_progress    = r_o_prog;
    assign o_taken_count = r_o_count;
    assign o_found       = r_o_found;
    assign o_failed      = r_o_failed;

endmodule

// ===== sv/delimiter_scan_kmp.sv =====
// Streaming delimiter search by Knuth-Morris-Pratt matching.
// The request channel i_in carries one stream byte per request with the flags
// stream_end and restart. The result channel o_out returns exactly one result per
// request: whether the byte was taken, the match progress, the bytes taken in this
// search, and the found and failed flags. The delimiter, its length, the border
// table and the byte limit are written on the configuration port; the user must
// write them only while idle, as the block itself does not enforce this. After a
// request is accepted, a byte that is taken walks the border chain one table step
// per cycle, one to eight steps; a request that takes no byte skips this walk.
// The result register is loaded once any walk has ended and the register is free,
// and a new request is accepted only after the previous result has been loaded.
// A finished result may wait in the output register while the next request is
// accepted and walked; while the receiver stalls and that register is full, the
// block holds the newer result internally and accepts nothing more.
// Reset clears the search state and the output valid flag and restores the
// register defaults: empty delimiter, empty table and a byte limit of 65535.
`include "delimiter_scan_kmp_macros.svh"

module delimiter_scan_kmp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dsk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dsk_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    dsk_in_if.sink                          i_in,
    dsk_out_if.source                       o_out
);

    dsk_pkg::t_cmd    w_cmd;
    dsk_pkg::t_status w_status;
    logic             w_in_ready;

    dsk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dsk_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_data_byte   (i_in.data_byte),
        .i_stream_end  (i_in.stream_end),
        .i_restart     (i_in.restart),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_byte_taken  (o_out.byte_taken),
        .o_progress    (o_out.progress),
        .o_taken_count (o_out.taken_count),
        .o_found       (o_out.found),
        .o_failed      (o_out.failed)
    );

    assign i_in.ready = w_in_ready;

    `DSK_ASSERT_NOW(a_emit_needs_room, i_clk, i_rst_n, w_cmd.emit, w_status.out_free)
    `DSK_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `DSK_ASSERT_NOW(a_one_outcome, i_clk, i_rst_n, o_out.valid, !(o_out.found && o_out.failed))

endmodule
